>>> src/kq_pkg.sv
package kq_pkg;

	localparam logic [31:0] KQ_NLF             = 32'h3A5C742E;
	localparam int          KQ_ROUNDS          = 528;
	localparam int          KQ_ROUNDS_PER_STAGE = 8;
	localparam int          KQ_NUM_STAGES      = KQ_ROUNDS / KQ_ROUNDS_PER_STAGE;
	localparam int          KQ_KEY_BITS        = 64;
	localparam logic [63:0] KQ_KEY_RESET       = 64'h442000760712425F;

	// register index decoded from paddr[3]
	localparam logic [0:0]  REG_CIPHER_KEY     = 1'b0;

	typedef enum logic [1:0] {
		ST_VALID       = 2'd0,
		ST_SECOND_FAIL = 2'd1,
		ST_FIRST_FAIL  = 2'd2
	} status_t;

	// clear-side packet data that rides along with the cipher word
	typedef struct packed {
		logic [7:0]        serial_hi;
		logic [7:0]        serial_mid;
		logic [7:0]        serial_tail;
		logic [7:0]        trailer;
		logic [7:0]        extra;
		logic signed [7:0] rssi;
		logic              two_way;
		logic [7:0]        exp_second;
		logic [7:0]        exp_top;
	} side_t;

	typedef struct packed {
		status_t           status;
		logic              two_way;
		logic [4:0]        command;
		logic [31:0]       serial_number;
		logic [15:0]       rolling_counter;
		logic [7:0]        aux_payload;
		logic signed [7:0] rssi;
	} result_t;

	function automatic logic [31:0] kq_round(input logic [31:0] x, input logic kb);
		logic [4:0] sel;
		logic       nb;
		sel = {x[30], x[25], x[19], x[8], x[0]};
		nb  = x[31] ^ x[15] ^ kb ^ KQ_NLF[sel];
		return {x[30:0], nb};
	endfunction

	function automatic logic [3:0] kq_popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

endpackage

>>> src/kq_rounds.sv
module kq_rounds
	import kq_pkg::*;
(
	input  logic [31:0]                    word_in,
	input  logic [KQ_ROUNDS_PER_STAGE-1:0] key_bits,
	output logic [31:0]                    word_out
);

	// key_bits holds the descending key slice: the first round takes the top bit
	always_comb begin
		logic [31:0] x;
		x = word_in;
		for (int j = 0; j < KQ_ROUNDS_PER_STAGE; j++) begin
			x = kq_round(x, key_bits[KQ_ROUNDS_PER_STAGE-1-j]);
		end
		word_out = x;
	end

endmodule

>>> src/kq_check.sv
module kq_check
	import kq_pkg::*;
(
	input  logic [31:0] plain_word,
	input  side_t       side,
	output result_t     result
);

	always_comb begin
		if (plain_word[23:16] != side.exp_second) begin
			result.status = ST_SECOND_FAIL;
		end else if (plain_word[31:24] != side.exp_top) begin
			result.status = ST_FIRST_FAIL;
		end else begin
			result.status = ST_VALID;
		end
		result.two_way         = side.two_way;
		result.command         = side.trailer[4:0];
		result.serial_number   = {side.serial_hi, side.serial_mid, side.serial_tail,
			side.trailer[7:5], 5'd0};
		result.rolling_counter = plain_word[15:0];
		result.aux_payload     = side.extra;
		result.rssi            = side.rssi;
	end

endmodule

>>> src/kq_cfg.sv
module kq_cfg
	import kq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [63:0]            pwdata,
	output logic [63:0]            prdata,
	output logic                   pready,
	output logic [KQ_KEY_BITS-1:0] cipher_key
);

	logic [KQ_KEY_BITS-1:0] key_q;
	logic                   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KQ_KEY_RESET;
		end else if (wr_en && paddr[3:3] == REG_CIPHER_KEY) begin
			key_q <= pwdata;
		end
	end

	always_comb begin
		if (paddr[3:3] == REG_CIPHER_KEY) begin
			prdata = key_q;
		end else begin
			prdata = 64'd0;
		end
	end

	assign cipher_key = key_q;

endmodule

>>> src/keeloq_packet_decrypt_verify.sv
// Channel   Direction  Handshake            Payload
// packet    in         start & !busy        cipher_word, serial_*, byte_seven/eight,
//                                           signal_strength
// result    out        done (one cycle)     status, two_way, command, serial_number,
//                                           rolling_counter, aux_payload,
//                                           signal_strength_out
// config    in         APB, pready tied 1   cipher_key at byte address 0
//
// One item per cycle. The 528 cipher rounds run as 66 register stages of 8
// rounds each; an item passes the capture stage, the 66 round stages and the
// result stage in order before its result is on the ports.
// busy is always low and nothing stalls; the receiver cannot hold results off.
// Reset clears the stage valid bits and loads the default key.
module keeloq_packet_decrypt_verify
	import kq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [31:0]       cipher_word,
	input  logic [7:0]        serial_hi,
	input  logic [7:0]        serial_mid,
	input  logic [7:0]        serial_tail,
	input  logic [7:0]        byte_seven,
	input  logic [7:0]        byte_eight,
	input  logic signed [7:0] signal_strength,
	output logic              done,
	output logic [1:0]        status,
	output logic              two_way,
	output logic [4:0]        command,
	output logic [31:0]       serial_number,
	output logic [15:0]       rolling_counter,
	output logic [7:0]        aux_payload,
	output logic signed [7:0] signal_strength_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	localparam int Latency = KQ_NUM_STAGES + 2;

	logic [KQ_KEY_BITS-1:0] cipher_key;
	logic                   accept;
	side_t                  side_in;

	logic                   vld_s  [KQ_NUM_STAGES+1];
	logic [31:0]            word_s [KQ_NUM_STAGES+1];
	side_t                  side_s [KQ_NUM_STAGES+1];

	result_t                result_nx;
	logic                   done_sout;
	result_t                result_sout;

	kq_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cipher_key (cipher_key)
	);

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// pick the last byte and extra byte, and build both expected check bytes up front
	always_comb begin
		side_in.two_way     = (byte_eight != 8'd0);
		side_in.trailer     = side_in.two_way ? byte_eight : byte_seven;
		side_in.extra       = side_in.two_way ? byte_seven : 8'd0;
		side_in.serial_hi   = serial_hi;
		side_in.serial_mid  = serial_mid;
		side_in.serial_tail = serial_tail;
		side_in.rssi        = signal_strength;
		side_in.exp_second  = {serial_tail[5:0], side_in.trailer[7:6]};
		side_in.exp_top     = {side_in.trailer[5:0], 2'b00} +
			{4'd0, kq_popcount8(side_in.extra)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s[0] <= cipher_word;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= KQ_NUM_STAGES; k++) begin : g_stage
		// key bit for round r is (15 - r) mod 64; one stage's rounds take a contiguous slice
		localparam int KeyHi = (15 - KQ_ROUNDS_PER_STAGE * (k - 1)) & (KQ_KEY_BITS - 1);
		localparam int KeyLo = KeyHi - (KQ_ROUNDS_PER_STAGE - 1);

		logic [31:0] word_nx;

		kq_rounds u_rounds (
			.word_in  (word_s[k-1]),
			.key_bits (cipher_key[KeyLo +: KQ_ROUNDS_PER_STAGE]),
			.word_out (word_nx)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[k-1]) begin
				word_s[k] <= word_nx;
				side_s[k] <= side_s[k-1];
			end
		end
	end

	kq_check u_check (
		.plain_word (word_s[KQ_NUM_STAGES]),
		.side       (side_s[KQ_NUM_STAGES]),
		.result     (result_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_sout <= 1'b0;
		end else begin
			done_sout <= vld_s[KQ_NUM_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[KQ_NUM_STAGES]) begin
			result_sout <= result_nx;
		end
	end

	assign done                = done_sout;
	assign status              = result_sout.status;
	assign two_way             = result_sout.two_way;
	assign command             = result_sout.command;
	assign serial_number       = result_sout.serial_number;
	assign rolling_counter     = result_sout.rolling_counter;
	assign aux_payload         = result_sout.aux_payload;
	assign signal_strength_out = result_sout.rssi;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##Latency done)
		else $error("accepted item did not produce a result at the pipeline latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, Latency))
		else $error("result strobe without a matching accepted item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3))
		else $error("undefined status code on result");

	a_one_way_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !two_way) |-> (aux_payload == 8'd0 && serial_number[4:0] == 5'd0))
		else $error("one-way result carries nonzero extra payload or serial low bits");

endmodule
